>>> sv/ace_pkg.sv
// shared types, constants and byte-selection functions of the ansi color cell encoder
// no dependencies; used by every other file of the block except ace_if

package ace_pkg;

    // configuration port
    localparam int AddrWidth = 3;
    localparam int DataWidth = 32;
    localparam logic [7:0] ColumnsReset = 8'd80;
    localparam logic [7:0] RowsReset    = 8'd25;

    // queue between front and back
    localparam int QueueDepth = 2;
    localparam int QueuePtrWidth = $clog2(QueueDepth);
    localparam int QueueCountWidth = $clog2(QueueDepth + 1);

    // byte slots of one cell, in emit order
    localparam int SlotCount = 19;
    localparam int SlotIdxWidth = $clog2(SlotCount);
    localparam logic [SlotIdxWidth-1:0] SlotHomeEsc    = 5'd0;
    localparam logic [SlotIdxWidth-1:0] SlotHomeBrk    = 5'd1;
    localparam logic [SlotIdxWidth-1:0] SlotHomeH      = 5'd2;
    localparam logic [SlotIdxWidth-1:0] SlotResetEsc   = 5'd3;
    localparam logic [SlotIdxWidth-1:0] SlotResetBrk   = 5'd4;
    localparam logic [SlotIdxWidth-1:0] SlotResetZero  = 5'd5;
    localparam logic [SlotIdxWidth-1:0] SlotResetM     = 5'd6;
    localparam logic [SlotIdxWidth-1:0] SlotSgrEsc     = 5'd7;
    localparam logic [SlotIdxWidth-1:0] SlotSgrBrk     = 5'd8;
    localparam logic [SlotIdxWidth-1:0] SlotCode1Hund  = 5'd9;
    localparam logic [SlotIdxWidth-1:0] SlotCode1Tens  = 5'd10;
    localparam logic [SlotIdxWidth-1:0] SlotCode1Ones  = 5'd11;
    localparam logic [SlotIdxWidth-1:0] SlotSemi       = 5'd12;
    localparam logic [SlotIdxWidth-1:0] SlotCode2Tens  = 5'd13;
    localparam logic [SlotIdxWidth-1:0] SlotCode2Ones  = 5'd14;
    localparam logic [SlotIdxWidth-1:0] SlotSgrM       = 5'd15;
    localparam logic [SlotIdxWidth-1:0] SlotChar       = 5'd16;
    localparam logic [SlotIdxWidth-1:0] SlotNewline    = 5'd17;
    localparam logic [SlotIdxWidth-1:0] SlotNul        = 5'd18;

    // ascii codes
    localparam logic [7:0] ChEsc     = 8'h1B;
    localparam logic [7:0] ChBracket = 8'h5B;
    localparam logic [7:0] ChH       = 8'h48;
    localparam logic [7:0] ChM       = 8'h6D;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChOne     = 8'h31;
    localparam logic [7:0] ChThree   = 8'h33;
    localparam logic [7:0] ChFour    = 8'h34;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChSemi    = 8'h3B;
    localparam logic [7:0] ChHash    = 8'h23;
    localparam logic [7:0] ChNewline = 8'h0A;
    localparam logic [7:0] ChNul     = 8'h00;

    // one classified cell as it travels from front to back
    typedef struct packed {
        logic [SlotCount-1:0] slots;    // which byte slots this cell emits
        logic                 code1_bg; // first sgr code is the background
        logic [7:0]           char_byte;
        logic [3:0]           fg;
        logic [3:0]           bg;
    } cell_rec_t;

    // push side of the queue
    typedef struct packed {
        logic      valid;
        cell_rec_t rec;
    } push_t;

    // decimal digits of the sgr codes: bg 40-47 / 100-107, fg 30-37 / 90-97
    function automatic logic [7:0] bg_tens(input logic [3:0] bg);
        return bg[3] ? ChZero : ChFour;
    endfunction

    function automatic logic [7:0] fg_tens(input logic [3:0] fg);
        return fg[3] ? ChNine : ChThree;
    endfunction

    function automatic logic [7:0] color_ones(input logic [3:0] c);
        return ChZero + {5'd0, c[2:0]};
    endfunction

    // byte carried by one slot of a cell
    function automatic logic [7:0] slot_byte(input cell_rec_t rec,
                                             input logic [SlotIdxWidth-1:0] idx);
        logic [7:0] b;
        b = ChNul;
        case (idx)
            SlotHomeEsc, SlotResetEsc, SlotSgrEsc: b = ChEsc;
            SlotHomeBrk, SlotResetBrk, SlotSgrBrk: b = ChBracket;
            SlotHomeH:     b = ChH;
            SlotResetZero: b = ChZero;
            SlotResetM, SlotSgrM: b = ChM;
            SlotCode1Hund: b = ChOne;
            SlotCode1Tens: b = rec.code1_bg ? bg_tens(rec.bg) : fg_tens(rec.fg);
            SlotCode1Ones: b = rec.code1_bg ? color_ones(rec.bg) : color_ones(rec.fg);
            SlotSemi:      b = ChSemi;
            SlotCode2Tens: b = fg_tens(rec.fg);
            SlotCode2Ones: b = color_ones(rec.fg);
            SlotChar:      b = rec.char_byte;
            SlotNewline:   b = ChNewline;
            SlotNul:       b = ChNul;
            default:       b = ChNul;
        endcase
        return b;
    endfunction

endpackage

>>> sv/ace_if.sv
// valid/ready channel interfaces of the ansi color cell encoder
// cell channel in, byte channel out; no dependencies

interface ace_cell_if;
    logic       valid;
    logic       ready;
    logic [7:0] cell_char;
    logic [3:0] cell_fg;
    logic [3:0] cell_bg;

    modport source (output valid, output cell_char, output cell_fg, output cell_bg,
                    input ready);
    modport sink (input valid, input cell_char, input cell_fg, input cell_bg,
                  output ready);
endinterface

interface ace_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       frame_end;

    modport source (output valid, output out_byte, output last_of_run, output frame_end,
                    input ready);
    modport sink (input valid, input out_byte, input last_of_run, input frame_end,
                  output ready);
endinterface

>>> sv/ace_front.sv
// front of the encoder: accepts cells, tracks frame position and colors, classifies
// depends on ace_pkg and ace_cell_if

module ace_front (
    input  logic             clk,
    input  logic             rst_n,
    ace_cell_if.sink         cells,
    input  logic [7:0]       columns,
    input  logic [7:0]       rows,
    input  logic             queue_full,
    output ace_pkg::push_t   push
);

    logic [3:0] last_fg_reg, last_fg_next;
    logic [3:0] last_bg_reg, last_bg_next;
    logic [7:0] column_count_reg, column_count_next;
    logic [7:0] row_count_reg, row_count_next;

    logic       accept;
    logic       frame_start;
    logic       bg_dif;
    logic       fg_dif;
    logic       esc;
    logic       eol;
    logic       eof;
    logic [7:0] col_inc;
    logic [7:0] row_inc;
    logic [3:0] ref_fg;
    logic [3:0] ref_bg;

    assign cells.ready = !queue_full;
    assign accept      = cells.valid && !queue_full;

    // classify the cell against the remembered colors and frame position
    always_comb
    begin
        frame_start = (column_count_reg == 8'd0) && (row_count_reg == 8'd0);
        ref_fg      = frame_start ? 4'd0 : last_fg_reg;
        ref_bg      = frame_start ? 4'd0 : last_bg_reg;
        bg_dif      = cells.cell_bg != ref_bg;
        fg_dif      = cells.cell_fg != ref_fg;
        esc         = bg_dif || fg_dif;
        col_inc     = column_count_reg + 8'd1;
        row_inc     = row_count_reg + 8'd1;
        eol         = (col_inc >= columns) || (col_inc == 8'd0);
        eof         = eol && ((row_inc >= rows) || (row_inc == 8'd0));
    end

    // build the queue entry
    always_comb
    begin
        push.valid = accept;
        push.rec.slots = '0;
        push.rec.slots[ace_pkg::SlotHomeEsc]   = frame_start;
        push.rec.slots[ace_pkg::SlotHomeBrk]   = frame_start;
        push.rec.slots[ace_pkg::SlotHomeH]     = frame_start;
        push.rec.slots[ace_pkg::SlotResetEsc]  = frame_start;
        push.rec.slots[ace_pkg::SlotResetBrk]  = frame_start;
        push.rec.slots[ace_pkg::SlotResetZero] = frame_start;
        push.rec.slots[ace_pkg::SlotResetM]    = frame_start;
        push.rec.slots[ace_pkg::SlotSgrEsc]    = esc;
        push.rec.slots[ace_pkg::SlotSgrBrk]    = esc;
        push.rec.slots[ace_pkg::SlotCode1Hund] = bg_dif && cells.cell_bg[3];
        push.rec.slots[ace_pkg::SlotCode1Tens] = esc;
        push.rec.slots[ace_pkg::SlotCode1Ones] = esc;
        push.rec.slots[ace_pkg::SlotSemi]      = bg_dif && fg_dif;
        push.rec.slots[ace_pkg::SlotCode2Tens] = bg_dif && fg_dif;
        push.rec.slots[ace_pkg::SlotCode2Ones] = bg_dif && fg_dif;
        push.rec.slots[ace_pkg::SlotSgrM]      = esc;
        push.rec.slots[ace_pkg::SlotChar]      = 1'b1;
        push.rec.slots[ace_pkg::SlotNewline]   = eol;
        push.rec.slots[ace_pkg::SlotNul]       = eof;
        push.rec.code1_bg  = bg_dif;
        push.rec.char_byte = (cells.cell_char == 8'd0) ? ace_pkg::ChHash : cells.cell_char;
        push.rec.fg        = cells.cell_fg;
        push.rec.bg        = cells.cell_bg;
    end

    // state update on an accepted cell
    always_comb
    begin
        last_fg_next      = last_fg_reg;
        last_bg_next      = last_bg_reg;
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        if (accept)
        begin
            last_fg_next      = cells.cell_fg;
            last_bg_next      = cells.cell_bg;
            column_count_next = eol ? 8'd0 : col_inc;
            row_count_next    = eof ? 8'd0 : (eol ? row_inc : row_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_fg_reg      <= 4'd0;
            last_bg_reg      <= 4'd0;
            column_count_reg <= 8'd0;
            row_count_reg    <= 8'd0;
        end
        else
        begin
            last_fg_reg      <= last_fg_next;
            last_bg_reg      <= last_bg_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    // a cell that closes the frame leaves the position at the frame start
    a_eof_resets_position: assert property (@(posedge clk) disable iff (!rst_n)
        accept && eof |=> column_count_reg == 8'd0 && row_count_reg == 8'd0)
        else $error("frame end did not reset position");

endmodule

>>> sv/ace_queue.sv
// short queue of classified cells between front and back
// depends on ace_pkg

module ace_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  ace_pkg::push_t     push,
    input  logic               pop,
    output logic               full,
    output logic               not_empty,
    output ace_pkg::cell_rec_t head
);

    ace_pkg::cell_rec_t entry_reg [ace_pkg::QueueDepth];
    logic [ace_pkg::QueuePtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [ace_pkg::QueuePtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [ace_pkg::QueueCountWidth-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign full      = count_reg == ace_pkg::QueueCountWidth'(ace_pkg::QueueDepth);
    assign not_empty = count_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push.valid && !full;
    assign do_pop    = pop && not_empty;

    // pointer wrap for any depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == ace_pkg::QueuePtrWidth'(ace_pkg::QueueDepth - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == ace_pkg::QueuePtrWidth'(ace_pkg::QueueDepth - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push.rec;
        end
    end

    // the front never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> !full)
        else $error("push into full queue");

endmodule

>>> sv/ace_back.sv
// back of the encoder: walks the byte slots of one cell into the output register
// depends on ace_pkg and ace_byte_if

module ace_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rec_avail,
    input  ace_pkg::cell_rec_t rec_in,
    output logic               pop,
    ace_byte_if.source         res
);

    ace_pkg::cell_rec_t cur_reg, cur_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;
    logic       out_end_reg, out_end_next;

    logic                                 busy;
    logic                                 emit;
    logic                                 last;
    logic [ace_pkg::SlotCount-1:0]        low_hot;
    logic [ace_pkg::SlotCount-1:0]        rest;
    logic [ace_pkg::SlotIdxWidth-1:0]     idx;

    assign busy = cur_reg.slots != '0;
    assign emit = busy && (!out_valid_reg || res.ready);

    // lowest pending slot and its index
    always_comb
    begin
        low_hot = cur_reg.slots & (~cur_reg.slots + ace_pkg::SlotCount'(1));
        rest    = cur_reg.slots & ~low_hot;
        last    = rest == '0;
        idx     = '0;
        for (int i = 0; i < ace_pkg::SlotCount; i++)
        begin
            if (low_hot[i])
            begin
                idx = ace_pkg::SlotIdxWidth'(i);
            end
        end
    end

    // take the next cell when idle or on the last byte of the current one
    assign pop = rec_avail && (!busy || (emit && last));

    always_comb
    begin
        cur_next = cur_reg;
        if (emit)
        begin
            cur_next.slots = rest;
        end
        if (pop)
        begin
            cur_next = rec_in;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_end_next   = out_end_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ace_pkg::slot_byte(cur_reg, idx);
            out_last_next  = last;
            out_end_next   = low_hot[ace_pkg::SlotNul];
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_reg       <= cur_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        out_byte_reg      <= out_byte_next;
        out_last_reg      <= out_last_next;
        out_end_reg       <= out_end_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.out_byte    = out_byte_reg;
    assign res.last_of_run = out_last_reg;
    assign res.frame_end   = out_end_reg;

    // the frame terminator is always the last byte of its cell
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_end |-> res.last_of_run)
        else $error("frame end not on last byte");

    // a new cell is loaded only when the current one is done
    a_pop_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        pop && busy |-> emit && last)
        else $error("cell replaced while bytes pending");

endmodule

>>> sv/ansi_color_cell_encoder.sv
// top level of the ansi color cell encoder: apb registers, front, queue and back
// depends on ace_pkg, ace_if, ace_front, ace_queue and ace_back
//
// Usage: text cells (character, 4-bit foreground, 4-bit background) enter on the
// cells channel in raster order; the ansi terminal stream leaves on the res channel,
// one byte per beat. last_of_run marks the final byte of each cell, frame_end the
// NUL that closes a frame. columns (0x0) and rows (0x4) are to be written over apb
// only while idle; the block does not enforce it. Reads return the current values.
// Path: cells pass the queue, the cell register of the back and the output register.
// Throughput: the back emits one byte per cycle while res is ready; a cell has from
// 1 byte (a plain character) up to 19 (frame header, color escape, newline and
// terminator). The front takes a cell every cycle while the two-entry
// queue has room; long escapes fill the queue and hold cells.ready low briefly.
// Reset: columns 80, rows 25, position at frame start, colors 0,0, queue and output
// empty. A stall on res holds the output register; the queue then fills and the
// cells channel stalls in turn, with no byte lost.

module ansi_color_cell_encoder (
    input  logic                          clk,
    input  logic                          rst_n,
    ace_cell_if.sink                      cells,
    ace_byte_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ace_pkg::AddrWidth-1:0] paddr,
    input  logic [ace_pkg::DataWidth-1:0] pwdata,
    output logic [ace_pkg::DataWidth-1:0] prdata,
    output logic                          pready
);

    logic [7:0] columns_reg, columns_next;
    logic [7:0] rows_reg, rows_next;
    logic       cfg_write;

    ace_pkg::push_t     push;
    ace_pkg::cell_rec_t head;
    logic               queue_full;
    logic               queue_not_empty;
    logic               pop;

    // apb register file
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_write)
        begin
            if (paddr[2])
            begin
                rows_next = pwdata[7:0];
            end
            else
            begin
                columns_next = pwdata[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= ace_pkg::ColumnsReset;
            rows_reg    <= ace_pkg::RowsReset;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
        end
    end

    assign prdata = {24'd0, (paddr[2] ? rows_reg : columns_reg)};

    // classify cells
    ace_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .columns    (columns_reg),
        .rows       (rows_reg),
        .queue_full (queue_full),
        .push       (push)
    );

    // decouple front and back
    ace_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head)
    );

    // serialize bytes
    ace_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_avail (queue_not_empty),
        .rec_in    (head),
        .pop       (pop),
        .res       (res)
    );

endmodule

>>> dv/ace_checker.sv
// stream checker of the ansi color cell encoder: watches the apb, cell and byte channels
// depends on ace_pkg and ace_if; predicts the byte stream of each cell and compares it

module ace_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    ace_cell_if                           cells,
    ace_byte_if                           res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic                          pready,
    input  logic [ace_pkg::AddrWidth-1:0] paddr,
    input  logic [ace_pkg::DataWidth-1:0] pwdata,
    output int                            fail_count,
    output int                            pending_count
);

    // register indexes
    localparam int RegColumns = 0;
    localparam int RegRows    = 1;

    // sgr code bases
    localparam int BgNormalBase = 40;
    localparam int BgBrightBase = 92;
    localparam int FgNormalBase = 30;
    localparam int FgBrightBase = 82;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       frame_end;
    } stream_beat_t;

    stream_beat_t stream_q[$];
    stream_beat_t want;
    stream_beat_t seen;
    logic [7:0]   columns_reg;
    logic [7:0]   rows_reg;
    logic [7:0]   col_pos;
    logic [7:0]   row_pos;
    logic [3:0]   cur_fg;
    logic [3:0]   cur_bg;
    int           errors;

    // append one byte of the terminal stream
    function automatic void emit(input logic [7:0] b);
        stream_q.push_back('{b, 1'b0, 1'b0});
    endfunction

    // sgr code in decimal, no leading zeros
    function automatic void emit_code(input int code);
        if (code > 99)
            emit(ace_pkg::ChZero + 8'((code / 100) % 10));
        if (code > 9)
            emit(ace_pkg::ChZero + 8'((code / 10) % 10));
        emit(ace_pkg::ChZero + 8'(code % 10));
    endfunction

    // all bytes caused by one cell, with position and color bookkeeping
    function automatic void encode_cell(input logic [7:0] ch, input logic [3:0] fg,
                                        input logic [3:0] bg);
        logic bg_dif;
        logic fg_dif;
        int   bg_code;
        int   fg_code;
        bg_code = int'(bg) + (bg < 4'd8 ? BgNormalBase : BgBrightBase);
        fg_code = int'(fg) + (fg < 4'd8 ? FgNormalBase : FgBrightBase);

        // frame header: cursor home and attribute reset
        if (col_pos == 8'd0 && row_pos == 8'd0)
        begin
            emit(ace_pkg::ChEsc);
            emit(ace_pkg::ChBracket);
            emit(ace_pkg::ChH);
            emit(ace_pkg::ChEsc);
            emit(ace_pkg::ChBracket);
            emit(ace_pkg::ChZero);
            emit(ace_pkg::ChM);
            cur_fg = 4'd0;
            cur_bg = 4'd0;
        end

        // color escape
        bg_dif = (bg != cur_bg);
        fg_dif = (fg != cur_fg);
        if (bg_dif || fg_dif)
        begin
            emit(ace_pkg::ChEsc);
            emit(ace_pkg::ChBracket);
            if (bg_dif)
            begin
                emit_code(bg_code);
                if (fg_dif)
                begin
                    emit(ace_pkg::ChSemi);
                    emit_code(fg_code);
                end
            end
            else
            begin
                emit_code(fg_code);
            end
            emit(ace_pkg::ChM);
        end

        emit(ch == 8'd0 ? ace_pkg::ChHash : ch);
        cur_fg = fg;
        cur_bg = bg;

        // row and frame ends; a count at or past the register also ends
        col_pos = col_pos + 8'd1;
        if (col_pos >= columns_reg || col_pos == 8'd0)
        begin
            emit(ace_pkg::ChNewline);
            col_pos = 8'd0;
            row_pos = row_pos + 8'd1;
            if (row_pos >= rows_reg || row_pos == 8'd0)
            begin
                emit(ace_pkg::ChNul);
                stream_q[stream_q.size()-1].frame_end = 1'b1;
                row_pos = 8'd0;
            end
        end
        stream_q[stream_q.size()-1].last_of_run = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_q.delete();
            columns_reg = ace_pkg::ColumnsReset;
            rows_reg    = ace_pkg::RowsReset;
            col_pos     = 8'd0;
            row_pos     = 8'd0;
            cur_fg      = 4'd0;
            cur_bg      = 4'd0;
            errors      = 0;
            fail_count    <= 0;
            pending_count <= 0;
        end
        else
        begin
            // compare an output beat with the oldest expected byte
            if (res.valid && res.ready)
            begin
                seen = '{res.out_byte, res.last_of_run, res.frame_end};
                if (stream_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: beat with nothing expected: byte=%h last=%b end=%b",
                             $time, seen.out_byte, seen.last_of_run, seen.frame_end);
                end
                else
                begin
                    want = stream_q.pop_front();
                    if (seen !== want)
                    begin
                        errors++;
                        $display("%0t: expected byte=%h last=%b end=%b, %s",
                                 $time, want.out_byte, want.last_of_run, want.frame_end,
                                 $sformatf("got byte=%h last=%b end=%b",
                                           seen.out_byte, seen.last_of_run,
                                           seen.frame_end));
                    end
                end
            end

            // register writes
            if (psel && penable && pwrite && pready)
            begin
                case (int'(paddr >> 2))
                    RegColumns: columns_reg = pwdata[7:0];
                    RegRows:    rows_reg    = pwdata[7:0];
                    default:    ;
                endcase
            end

            // accepted cell
            if (cells.valid && cells.ready)
                encode_cell(cells.cell_char, cells.cell_fg, cells.cell_bg);

            fail_count    <= errors;
            pending_count <= stream_q.size();
        end
    end

endmodule

>>> dv/testbench.sv
// top of the ansi color cell encoder testbench: clock, reset, apb writes and cell stimulus
// depends on ace_pkg, ace_if, ansi_color_cell_encoder and ace_checker

module testbench;

    // register addresses
    localparam logic [ace_pkg::AddrWidth-1:0] AddrColumns = 3'd0;
    localparam logic [ace_pkg::AddrWidth-1:0] AddrRows    = 3'd4;

    localparam int HoldCycles     = 150;
    localparam int DrainCycles    = 4;
    localparam int RandomPerPhase = 105;
    localparam int PhaseCount     = 4;
    localparam int SendIdle[PhaseCount]  = '{0, 67, 0, 33};
    localparam int RecvStall[PhaseCount] = '{0, 0, 67, 33};

    logic                          clk;
    logic                          rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [ace_pkg::AddrWidth-1:0] paddr;
    logic [ace_pkg::DataWidth-1:0] pwdata;
    logic [ace_pkg::DataWidth-1:0] prdata;
    logic                          pready;
    int                            fail_count;
    int                            pending_count;
    int                            send_idle;
    int                            recv_stall;
    int                            hold_req;
    int                            hold_seen;
    int                            hold_left;
    logic [7:0]                    char_now;
    logic [3:0]                    fg_now;
    logic [3:0]                    bg_now;

    ace_cell_if cell_ch ();
    ace_byte_if res_ch ();

    ansi_color_cell_encoder u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cells   (cell_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    ace_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cells         (cell_ch),
        .res           (res_ch),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

    // byte receiver: random stalls plus long hold-offs on request
    initial
    begin
        res_ch.ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HoldCycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= ($urandom_range(99) >= recv_stall);
            end
        end
    end

    // apb write: setup then access
    task automatic write_reg(input logic [ace_pkg::AddrWidth-1:0] addr,
                             input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // offer one cell, with random idle cycles ahead of it
    task automatic send_cell(input logic [7:0] ch, input logic [3:0] fg, input logic [3:0] bg);
        while ($urandom_range(99) < send_idle)
        begin
            cell_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cell_ch.valid     <= 1'b1;
        cell_ch.cell_char <= ch;
        cell_ch.cell_fg   <= fg;
        cell_ch.cell_bg   <= bg;
        do @(posedge clk); while (!cell_ch.ready);
    endtask

    // stop offering and wait until every expected byte has arrived
    task automatic wait_drained();
        cell_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_count != 0);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // frame dimension, extremes weighted in
    function automatic logic [7:0] random_dim();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 8'd0;
        if (r < 18)
            return 8'd255;
        if (r < 28)
            return 8'd1;
        return 8'($urandom_range(6, 2));
    endfunction

    // stimulus and verdict
    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cell_ch.valid     = 1'b0;
        cell_ch.cell_char = 8'd0;
        cell_ch.cell_fg   = 4'd0;
        cell_ch.cell_bg   = 4'd0;
        send_idle         = 0;
        recv_stall        = 0;
        hold_req          = 0;
        fg_now            = 4'd0;
        bg_now            = 4'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset dimensions: zero char, both colors, bright bg only, fg only
        send_cell(8'h00, 4'd0, 4'd0);
        send_cell(8'hFF, 4'd15, 4'd15);
        send_cell(8'h41, 4'd15, 4'd8);
        send_cell(8'h42, 4'd7, 4'd8);
        send_cell(8'h43, 4'd8, 4'd7);
        send_cell(8'h7F, 4'd0, 4'd0);

        // columns below the current count, then a full 3x2 frame end
        wait_drained();
        write_reg(AddrColumns, 8'd3);
        write_reg(AddrRows, 8'd2);
        send_cell(8'h80, 4'd1, 4'd0);
        send_cell(8'h20, 4'd1, 4'd0);
        send_cell(8'h7E, 4'd1, 4'd9);
        send_cell(8'h01, 4'd14, 4'd9);
        send_cell(8'h55, 4'd6, 4'd2);

        // zero dimensions: every cell ends a frame
        wait_drained();
        write_reg(AddrColumns, 8'd0);
        write_reg(AddrRows, 8'd0);
        send_cell(8'h00, 4'd9, 4'd12);
        send_cell(8'hAA, 4'd0, 4'd0);

        // largest dimensions
        wait_drained();
        write_reg(AddrColumns, 8'd255);
        write_reg(AddrRows, 8'd255);
        send_cell(8'h61, 4'd3, 4'd5);
        send_cell(8'h62, 4'd11, 4'd13);

        // single-cell frames
        wait_drained();
        write_reg(AddrColumns, 8'd1);
        write_reg(AddrRows, 8'd1);
        send_cell(8'h63, 4'd11, 4'd13);
        send_cell(8'h64, 4'd2, 4'd10);

        // random phases, each with its own idling and dimensions
        for (int p = 0; p < PhaseCount; p++)
        begin
            wait_drained();
            send_idle  = SendIdle[p];
            recv_stall = RecvStall[p];
            write_reg(AddrColumns, random_dim());
            write_reg(AddrRows, random_dim());
            for (int i = 0; i < RandomPerPhase; i++)
            begin
                // long receiver hold-off while cells keep coming
                if (p == 0 && i == 20)
                    hold_req++;
                if (i == RandomPerPhase / 2)
                begin
                    wait_drained();
                    write_reg(AddrColumns, random_dim());
                end
                // colors mostly kept, so many cells are a bare character
                if ($urandom_range(99) < 30)
                    fg_now = 4'($urandom_range(15));
                if ($urandom_range(99) < 30)
                    bg_now = 4'($urandom_range(15));
                char_now = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(255));
                send_cell(char_now, fg_now, bg_now);
            end
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
